### rtl/sxt_pkg.sv
// Shared types and constants for the S-expression tokenizer.
`default_nettype none

package sxt_pkg;

  // Event codes on the result channel
  typedef enum logic [2:0] {
    EV_BYTE   = 3'd0,
    EV_SYMEND = 3'd1,
    EV_OPEN   = 3'd2,
    EV_CLOSE  = 3'd3,
    EV_EOS    = 3'd4,
    EV_ERROR  = 3'd5
  } ev_kind_t;

  // Error codes carried with an error event
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_DELIM = 2'd1,
    ERR_EMPTY_ID  = 2'd2,
    ERR_OPEN_STR  = 2'd3
  } err_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified request: a first event and an optional trailing event
  // (close paren or end of stream after a symbol end)
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  sym_byte;
    logic        is_str;
    err_t        err;
    logic        two;
    ev_kind_t    kind2;
  } tok_op_t;

  // Push side of the queue
  typedef struct packed {
    logic    valid;
    tok_op_t op;
  } tok_push_t;

  // Head side of the queue
  typedef struct packed {
    logic    avail;
    tok_op_t op;
  } tok_head_t;

endpackage

`default_nettype wire

### rtl/sxt_if.sv
// Channel interfaces: character input and event output.
`default_nettype none

interface sxt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sxt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] sym_byte;
  logic       sym_is_string;
  logic [1:0] err_code;
  logic       last_of_run;

  modport source (output valid, output event_kind, output sym_byte, output sym_is_string,
                  output err_code, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input sym_byte, input sym_is_string,
                input err_code, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/sexpr_tokenizer_top.sv
// S-expression tokenizer top level: front end, request queue and back end.
//
// chars:  one source byte per request (ch); byte 0 marks end of stream.
// events: one lexer event per request: symbol byte, symbol end, open or close
//         paren, end of stream or error, with last_of_run on the final event
//         caused by a byte. A byte gives zero, one or two events.
// Both channels use valid/ready; a request moves when both are high.
// Path: a taken byte's request is written into the queue, then loaded into the
// back end's held request register, from which its event is offered.
// Throughput: one byte per cycle in while the queue is not full and one event per
// cycle out while events.ready is high; a byte that gives two events holds the back
// end for both, which the queue (QUEUE_DEPTH requests) absorbs.
// Stall: while events.ready is low the back end holds its event and the
// queue fills; chars.ready drops only when the queue is full.
// Reset (rst, synchronous): lexer returns to between tokens, the error halt
// clears and the queue empties. After an error event the block takes bytes
// but gives nothing more until reset.
`default_nettype none

module sexpr_tokenizer_top import sxt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  sxt_in_if.sink    chars,
  sxt_out_if.source events
);

  tok_push_t push;
  tok_head_t head;
  logic      q_ready;
  logic      pop;

  sxt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ch_valid (chars.valid),
    .ch       (chars.ch),
    .q_ready  (q_ready),
    .ch_ready (chars.ready),
    .push     (push)
  );

  sxt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .ready (q_ready),
    .head  (head)
  );

  sxt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .ev_ready      (events.ready),
    .ev_valid      (events.valid),
    .event_kind    (events.event_kind),
    .sym_byte      (events.sym_byte),
    .sym_is_string (events.sym_is_string),
    .err_code      (events.err_code),
    .last_of_run   (events.last_of_run)
  );

endmodule

`default_nettype wire

### rtl/sxt_front.sv
// Front end: takes characters, tracks the lexer mode and classifies each byte.
`default_nettype none

module sxt_front import sxt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      ch_valid,
  input  wire logic [7:0] ch,
  input  wire logic      q_ready,
  output logic           ch_ready,
  output tok_push_t      push
);

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_STRING = 3'd2,
    M_ESCAPE = 3'd3,
    M_QUOTED = 3'd4
  } mode_t;

  mode_t   mode, mode_next;
  logic    halted, halted_next;
  logic    accept;
  logic    has_res;
  tok_op_t op;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic tok_op_t mk(input ev_kind_t k, input logic [7:0] b, input logic s,
                                 input err_t e);
    tok_op_t o;
    o.kind     = k;
    o.sym_byte = b;
    o.is_str   = s;
    o.err      = e;
    o.two      = 1'b0;
    o.kind2    = EV_CLOSE;
    return o;
  endfunction

  // Symbol end on a delimiter; anything else is a bad delimiter
  function automatic tok_op_t end_sym(input logic [7:0] c, input logic s);
    tok_op_t o;
    o = mk(EV_SYMEND, 8'h00, s, ERR_NONE);
    if (is_space(c)) begin
      o.two = 1'b0;
    end else if (c == CH_RPAREN) begin
      o.two   = 1'b1;
      o.kind2 = EV_CLOSE;
    end else if (c == CH_NUL) begin
      o.two   = 1'b1;
      o.kind2 = EV_EOS;
    end else begin
      o = mk(EV_ERROR, 8'h00, 1'b0, ERR_BAD_DELIM);
    end
    return o;
  endfunction

  assign ch_ready = q_ready;
  assign accept   = ch_valid && ch_ready;

  // Per-byte classification
  always_comb begin
    mode_next = mode;
    has_res   = 1'b0;
    op        = mk(EV_BYTE, ch, 1'b0, ERR_NONE);
    unique case (mode)
      M_IDENT: begin
        has_res = 1'b1;
        if (is_space(ch) || ch == CH_RPAREN || ch == CH_NUL || ch == CH_LPAREN ||
            ch == CH_QUOTE || ch == CH_SEMI || ch == CH_BSLASH) begin
          op        = end_sym(ch, 1'b0);
          mode_next = M_IDLE;
        end
      end
      M_STRING: begin
        if (ch == CH_NUL) begin
          has_res = 1'b1;
          op      = mk(EV_ERROR, 8'h00, 1'b0, ERR_OPEN_STR);
        end else if (ch == CH_BSLASH) begin
          mode_next = M_ESCAPE;
        end else begin
          has_res = 1'b1;
          op      = mk(EV_BYTE, ch, 1'b1, ERR_NONE);
          if (ch == CH_QUOTE) mode_next = M_QUOTED;
        end
      end
      M_ESCAPE: begin
        has_res = 1'b1;
        if (ch == CH_NUL) begin
          op = mk(EV_ERROR, 8'h00, 1'b0, ERR_OPEN_STR);
        end else begin
          op        = mk(EV_BYTE, ch, 1'b1, ERR_NONE);
          mode_next = M_STRING;
        end
      end
      M_QUOTED: begin
        has_res   = 1'b1;
        op        = end_sym(ch, 1'b1);
        mode_next = M_IDLE;
      end
      default: begin
        mode_next = M_IDLE;
        has_res   = 1'b1;
        if (ch == CH_NUL) begin
          op = mk(EV_EOS, 8'h00, 1'b0, ERR_NONE);
        end else if (ch == CH_LPAREN) begin
          op = mk(EV_OPEN, 8'h00, 1'b0, ERR_NONE);
        end else if (ch == CH_RPAREN) begin
          op = mk(EV_CLOSE, 8'h00, 1'b0, ERR_NONE);
        end else if (is_space(ch)) begin
          has_res = 1'b0;
        end else if (ch == CH_QUOTE) begin
          op        = mk(EV_BYTE, ch, 1'b1, ERR_NONE);
          mode_next = M_STRING;
        end else if (ch == CH_SEMI || ch == CH_BSLASH) begin
          op = mk(EV_ERROR, 8'h00, 1'b0, ERR_EMPTY_ID);
        end else begin
          op        = mk(EV_BYTE, ch, 1'b0, ERR_NONE);
          mode_next = M_IDENT;
        end
      end
    endcase
    // an error halts the lexer until reset
    halted_next = halted;
    if (has_res && op.kind == EV_ERROR) begin
      halted_next = 1'b1;
      mode_next   = M_IDLE;
    end
  end

  assign push.valid = accept && !halted && has_res;
  assign push.op    = op;

  // Mode and halt state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      halted <= 1'b0;
    end else if (accept && !halted) begin
      mode   <= mode_next;
      halted <= halted_next;
    end
  end

`ifndef ASSERT_OFF
  a_halt_silent: assert property (@(posedge clk) disable iff (rst) halted |-> !push.valid)
    else $error("request pushed while halted");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    push.valid && push.op.kind == EV_ERROR |=> halted)
    else $error("error did not halt the lexer");
`endif

endmodule

`default_nettype wire

### rtl/sxt_queue.sv
// Short queue of classified requests between front and back.
`default_nettype none

module sxt_queue import sxt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tok_push_t push,
  input  wire logic      pop,
  output logic           ready,
  output tok_head_t      head
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_op_t            slots [DEPTH];
  logic [IDX_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign ready      = count != CNT_W'(DEPTH);
  assign do_push    = push.valid && ready;
  assign do_pop     = pop && head.avail;
  assign head.avail = count != '0;
  assign head.op    = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.op;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
  a_no_drop: assert property (@(posedge clk) disable iff (rst) push.valid |-> ready)
    else $error("request pushed into a full queue");
`endif

endmodule

`default_nettype wire

### rtl/sxt_back.sv
// Back end: plays out one or two events per request on the result channel.
`default_nettype none

module sxt_back import sxt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tok_head_t head,
  output logic           pop,
  input  wire logic      ev_ready,
  output logic           ev_valid,
  output logic [2:0]     event_kind,
  output logic [7:0]     sym_byte,
  output logic           sym_is_string,
  output logic [1:0]     err_code,
  output logic           last_of_run
);

  tok_op_t cur;
  logic    cur_valid;
  logic    phase;
  logic    is_last;
  logic    take;

  assign is_last = !cur.two || phase;
  assign take    = ev_valid && ev_ready;
  assign pop     = head.avail && (!cur_valid || (take && is_last));

  // Output fields from the held request
  assign ev_valid      = cur_valid;
  assign event_kind    = phase ? cur.kind2 : cur.kind;
  assign sym_byte      = phase ? 8'h00 : cur.sym_byte;
  assign sym_is_string = phase ? 1'b0 : cur.is_str;
  assign err_code      = phase ? ERR_NONE : cur.err;
  assign last_of_run   = is_last;

  // Held request payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head.op;
  end

  // Held request control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (take && is_last) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (take) begin
      phase     <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_phase_two: assert property (@(posedge clk) disable iff (rst) phase |-> cur_valid && cur.two)
    else $error("second event without a two-event request");
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_kind == EV_ERROR |-> last_of_run)
    else $error("error event not marked last");
`endif

endmodule

`default_nettype wire
